>>> rtl/brq_pkg.sv
// ----------------------------------------------------------------------------
// brq_pkg
// shared constants and helpers for the bit vector rank query core
// ----------------------------------------------------------------------------
`default_nettype none

package brq_pkg;

    localparam int MAX_BLOCKS   = 1024;
    localparam int SEGMENT_BITS = 8;
    localparam int SEG_SHIFT    = $clog2(SEGMENT_BITS);
    localparam int BIT_MSB      = SEGMENT_BITS - 1;
    localparam int CAP_BITS     = MAX_BLOCKS * SEGMENT_BITS;

    localparam int COUNT_W  = 14;
    localparam int BLOCK_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PTR_W    = $clog2(MAX_BLOCKS + 1);
    localparam int ENTRY_W  = COUNT_W + SEGMENT_BITS;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RANK = 1'b1;

    typedef logic [COUNT_W-1:0]      count_t;
    typedef logic [SEGMENT_BITS-1:0] block_t;
    typedef logic [BLOCK_AW-1:0]     block_addr_t;
    typedef logic [PTR_W-1:0]        load_ptr_t;
    typedef logic [SEG_SHIFT-1:0]    bit_idx_t;

    function automatic count_t popcount(input block_t v);
        count_t c;
        c = '0;
        for (int i = 0; i < SEGMENT_BITS; i++)
        begin
            c = c + count_t'(v[i]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/brq_ram.sv
// ----------------------------------------------------------------------------
// brq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module brq_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bitvector_rank_query_core.sv
// ----------------------------------------------------------------------------
// bitvector_rank_query_core
// rank over a bit vector loaded as 8-bit blocks, each kept with its prefix count
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  input     in_valid/in_ready, func, block_data, position  in
//  result    out_valid/out_ready, rank_value, out_of_range  out
//  config    cfg_wr_en, cfg_wr_data (total_bits)            in
//
//  a load is one write of block and prefix into the shared store
//  a query is a registered store read, then popcount and add
//  a query waits in S_READ while an earlier result is not taken
//  loads are taken while a result waits; no clearing pass after reset
// ----------------------------------------------------------------------------
`default_nettype none

module bitvector_rank_query_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    func,
    input  wire logic [7:0]              block_data,
    input  wire logic [brq_pkg::COUNT_W-1:0] position,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [brq_pkg::COUNT_W-1:0]  rank_value,
    output logic                         out_of_range,
    input  wire logic                    cfg_wr_en,
    input  wire logic [brq_pkg::COUNT_W-1:0] cfg_wr_data
);

    import brq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    count_t      total_bits_reg, total_bits_next;
    count_t      running_reg, running_next;
    load_ptr_t   load_ptr_reg, load_ptr_next;
    logic        out_valid_reg, out_valid_next;
    count_t      rank_reg, rank_next;
    logic        oor_reg, oor_next;
    bit_idx_t    bit_idx_reg, bit_idx_next;
    logic        err_reg, err_next;

    logic        in_fire;
    logic        load_fire;
    logic        rank_fire;
    logic        load_room;
    count_t      pos_m1;
    logic        pos_err;
    logic        ram_wr_en;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;
    block_addr_t ram_wr_addr;
    block_addr_t ram_rd_addr;
    block_t      rd_block;
    count_t      rd_prefix;
    block_t      bit_mask;
    logic        res_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (func == FUNC_LOAD);
    assign rank_fire = in_fire && (func == FUNC_RANK);
    assign load_room = (32'(load_ptr_reg) < MAX_BLOCKS);

    assign pos_m1  = position - count_t'(1);
    assign pos_err = (position == '0) || (position > total_bits_reg)
                     || (32'(position) > CAP_BITS);

    // block in the low bits, prefix count above it
    assign ram_wr_en   = load_fire && load_room && !cfg_wr_en;
    assign ram_wr_addr = block_addr_t'(load_ptr_reg);
    assign ram_wr_data = {running_reg, block_data};
    assign ram_rd_addr = block_addr_t'(pos_m1[COUNT_W-1:SEG_SHIFT]);

    brq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (rank_fire),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_block  = ram_rd_data[SEGMENT_BITS-1:0];
    assign rd_prefix = ram_rd_data[ENTRY_W-1:SEGMENT_BITS];
    assign bit_mask  = {SEGMENT_BITS{1'b1}} >> (BIT_MSB - int'(bit_idx_reg));
    assign res_load  = (state_reg == S_READ) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        total_bits_next = total_bits_reg;
        running_next    = running_reg;
        load_ptr_next   = load_ptr_reg;
        out_valid_next  = out_valid_reg;
        rank_next       = rank_reg;
        oor_next        = oor_reg;
        bit_idx_next    = bit_idx_reg;
        err_next        = err_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (rank_fire)
                begin
                    bit_idx_next = pos_m1[SEG_SHIFT-1:0];
                    err_next     = pos_err;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                if (res_load)
                begin
                    out_valid_next = 1'b1;
                    oor_next       = err_reg;
                    rank_next      = err_reg ? '0 : rd_prefix + popcount(rd_block & bit_mask);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            total_bits_next = cfg_wr_data;
            running_next    = '0;
            load_ptr_next   = '0;
        end
        else if (ram_wr_en)
        begin
            running_next  = running_reg + popcount(block_data);
            load_ptr_next = load_ptr_reg + load_ptr_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_bits_reg <= '0;
            running_reg    <= '0;
            load_ptr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_bits_reg <= total_bits_next;
            running_reg    <= running_next;
            load_ptr_reg   <= load_ptr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg    <= rank_next;
        oor_reg     <= oor_next;
        bit_idx_reg <= bit_idx_next;
        err_reg     <= err_next;
    end

    assign out_valid    = out_valid_reg;
    assign rank_value   = rank_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

>>> rtl/brq_checker.sv
// ----------------------------------------------------------------------------
// brq_checker
// port-level checks for the bit vector rank query core
// ----------------------------------------------------------------------------
`default_nettype none

module brq_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        func,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [brq_pkg::COUNT_W-1:0] rank_value,
    input  wire logic                        out_of_range
);

    import brq_pkg::*;

    // a rejected query always reports a zero rank
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> rank_value == '0)
        else $error("out_of_range item with non-zero rank_value");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rank_value)
                                    && $stable(out_of_range))
        else $error("result item changed while stalled");

    // a query holds off the input while its store read is in flight
    a_rank_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_RANK |=> !in_ready)
        else $error("input taken during query read cycle");

    // loads never stall the input
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_LOAD |=> in_ready)
        else $error("input stalled after a load");

    // a result appears only out of the query read cycle
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result item without a query in flight");

endmodule

bind bitvector_rank_query_core brq_checker u_brq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rank_value   (rank_value),
    .out_of_range (out_of_range)
);

`default_nettype wire
